/* src/cls_pkg.sv */
package cls_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int KIND_W  = 2;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int FIDX_W  = 6;
    localparam int ECNT_W  = 7;

    localparam logic [KIND_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] REQ_SEARCH = 2'd1;
    localparam logic [KIND_W-1:0] REQ_DELETE = 2'd2;
    localparam logic [KIND_W-1:0] REQ_UNUSED = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]         req_type;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [FIDX_W-1:0] found_index;
        logic [ECNT_W-1:0] entry_count;
    } rsp_t;

    // Command broadcast from the control logic to every cell.
    typedef struct packed {
        logic do_insert;
        logic do_delete;
    } cell_cmd_t;

endpackage

/* src/cls_cell.sv */
module cls_cell #(
    parameter int CAPACITY = cls_pkg::CAPACITY_DEF,
    parameter int INDEX    = 0
) (
    input  logic                                clk,
    input  cls_pkg::cell_cmd_t                  cmd,
    input  logic [cls_pkg::VALUE_W-1:0]         key,
    input  logic [$clog2(CAPACITY+1)-1:0]       count,
    input  logic [cls_pkg::VALUE_W-1:0]         next_entry,
    input  logic                                hit_in,
    input  logic [$clog2(CAPACITY)-1:0]         idx_in,
    output logic [cls_pkg::VALUE_W-1:0]         entry,
    output logic                                hit_out,
    output logic [$clog2(CAPACITY)-1:0]         idx_out
);
    import cls_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY+1);
    localparam int IDX_W = $clog2(CAPACITY);

    logic [VALUE_W-1:0] entry_reg;
    logic [VALUE_W-1:0] entry_next;
    logic               in_use;
    logic               match;
    logic               first;

    assign in_use  = CNT_W'(INDEX) < count;
    assign match   = in_use && (entry_reg == key);
    assign first   = match && !hit_in;
    assign hit_out = hit_in || match;
    assign idx_out = first ? IDX_W'(INDEX) : idx_in;
    assign entry   = entry_reg;

    // On a delete, the matching cell and every cell after it take the
    // neighbor's entry, which closes the gap.
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.do_insert && (count == CNT_W'(INDEX)))
        begin
            entry_next = key;
        end
        else if (cmd.do_delete && hit_out)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

/* src/compacting_list_search_delete.sv */
// Channel   Ports              Handshake
// request   req                taken at a clock edge with start high and busy low
// result    rsp                shown for one cycle while done is high
//
// An item is taken at a clock edge; busy then goes high while every cell
// compares its entry and the first match ripples down the chain. The result
// appears in the cycle after that, when busy is low again; no new item is
// taken while busy is high. Reset clears the count and the control state;
// entries hold no reset value. The receiver cannot stall.
module compacting_list_search_delete #(
    parameter int CAPACITY = cls_pkg::CAPACITY_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  cls_pkg::req_t req,
    output logic          busy,
    output logic          done,
    output cls_pkg::rsp_t rsp
);
    import cls_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY+1);
    localparam int IDX_W = $clog2(CAPACITY);

    logic               busy_reg;
    logic               done_reg;
    logic [KIND_W-1:0]  kind_reg;
    logic [VALUE_W-1:0] key_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;

    logic               hit_c   [CAPACITY+1];
    logic [IDX_W-1:0]   idx_c   [CAPACITY+1];
    logic [VALUE_W-1:0] entry_c [CAPACITY];
    cell_cmd_t          cmd;
    logic               found;
    logic               full;

    assign hit_c[0] = 1'b0;
    assign idx_c[0] = '0;
    assign found    = hit_c[CAPACITY];
    assign full     = count_reg >= CNT_W'(CAPACITY);

    assign cmd.do_insert = busy_reg && (kind_reg == REQ_INSERT) && !full;
    assign cmd.do_delete = busy_reg && (kind_reg == REQ_DELETE) && found;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            cls_cell #(
                .CAPACITY (CAPACITY),
                .INDEX    (g)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .key        (key_reg),
                .count      (count_reg),
                .next_entry ((g == CAPACITY-1) ? entry_c[g] : entry_c[(g+1) % CAPACITY]),
                .hit_in     (hit_c[g]),
                .idx_in     (idx_c[g]),
                .entry      (entry_c[g]),
                .hit_out    (hit_c[g+1]),
                .idx_out    (idx_c[g+1])
            );
        end
    endgenerate

    always_comb
    begin
        count_next           = count_reg;
        rsp_next.status      = ST_OK;
        rsp_next.found_index = '0;
        case (kind_reg)
            REQ_INSERT:
            begin
                if (full)
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            REQ_SEARCH:
            begin
                if (found)
                begin
                    rsp_next.found_index = FIDX_W'(idx_c[CAPACITY]);
                end
                else
                begin
                    rsp_next.status = ST_NOT_FOUND;
                end
            end
            REQ_DELETE:
            begin
                if (found)
                begin
                    rsp_next.found_index = FIDX_W'(idx_c[CAPACITY]);
                    count_next           = count_reg - CNT_W'(1);
                end
                else
                begin
                    rsp_next.status = ST_NOT_FOUND;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        rsp_next.entry_count = ECNT_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg;
            if (busy_reg)
            begin
                busy_reg  <= 1'b0;
                count_reg <= count_next;
            end
            else if (start)
            begin
                busy_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            kind_reg <= req.req_type;
            key_reg  <= req.value;
        end
        if (busy_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

/* src/cls_checker.sv */
module cls_checker #(
    parameter int CAPACITY = cls_pkg::CAPACITY_DEF
) (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input cls_pkg::rsp_t rsp
);
    import cls_pkg::*;

    a_take_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("item taken but busy did not rise");

    a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("work cycle not followed by a result");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without an item in work");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp.status == ST_FULL) |-> rsp.entry_count == ECNT_W'(CAPACITY))
        else $error("insert refused while the list was not full");

    a_fail_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp.status != ST_OK) |-> rsp.found_index == '0)
        else $error("failed request reports a nonzero index");

endmodule

bind compacting_list_search_delete cls_checker #(
    .CAPACITY (CAPACITY)
) u_cls_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);
